[rtl/gsa_pkg.sv]
// Shared types and constants for the generational slot allocator.
// No dependencies.
`default_nettype none
package gsa_pkg;

  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SEQ_W  = 32;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RETAG  = 2'd2,
    OP_VERIFY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BAD   = 2'd2,
    ST_STALE = 2'd3
  } status_t;

  // one table row: in-use mark, sequence, free-list link
  typedef struct packed {
    logic              used;
    logic [SEQ_W-1:0]  seq;
    logic [SLOT_W-1:0] link;
  } row_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic exec;
  } gsa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } gsa_sts_t;

endpackage
`default_nettype wire

[rtl/generational_slot_allocator.sv]
// Generational slot allocator: free-list handle table with sequence tags.
// Flow: the table row is read on accept and written back on execute, which
//   registers the result once the output is free; no new beat is taken until
//   then, due to this read-modify-write of the single slot table row.
// Reset: a clearing pass over every table row rebuilds the free list and zeroes
//   sequences and in-use marks; in_tready stays low until it finishes.
`default_nettype none
module generational_slot_allocator
  import gsa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // slot_index[9:0], tag_seq[41:10], zero pad
  input  wire logic [1:0]             in_tuser,   // kind[1:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // result_slot[9:0], result_seq[41:10],
                                                  // used_count[51:42], zero pad
  output logic [1:0]                  out_tuser   // status[1:0]
);

  gsa_cmd_t          cmd;
  gsa_sts_t          sts;
  logic [SLOT_W-1:0] out_slot;
  logic [SEQ_W-1:0]  out_seq;
  logic [SLOT_W-1:0] out_used;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gsa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_tuser),
    .in_slot    (in_tdata[SLOT_W-1:0]),
    .in_tag     (in_tdata[SLOT_W+SEQ_W-1:SLOT_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_slot   (out_slot),
    .out_seq    (out_seq),
    .out_used   (out_used)
  );

  assign out_tdata = {(OUT_TDATA_W - 2*SLOT_W - SEQ_W)'(0), out_used, out_seq, out_slot};

endmodule
`default_nettype wire

[rtl/gsa_ctrl.sv]
// Sequencer for the slot allocator: table clear after reset, accept, execute.
// Depends on gsa_pkg.
`default_nettype none
module gsa_ctrl
  import gsa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire gsa_sts_t sts,
  output gsa_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/gsa_dp.sv]
// Datapath for the slot allocator: slot table memory, free-list head,
// use count, operation registers and the output register. Depends on gsa_pkg.
`default_nettype none
module gsa_dp
  import gsa_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire gsa_cmd_t                cmd,
  output gsa_sts_t                     sts,
  input  wire logic [1:0]              in_kind,
  input  wire logic [SLOT_W-1:0]       in_slot,
  input  wire logic [SEQ_W-1:0]        in_tag,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_status,
  output logic [SLOT_W-1:0]            out_slot,
  output logic [SEQ_W-1:0]             out_seq,
  output logic [SLOT_W-1:0]            out_used
);

  row_t mem [SLOTS];

  row_t              rd_r;
  op_t               op_kind_r;
  logic [SLOT_W-1:0] op_idx_r;
  logic [SEQ_W-1:0]  op_tag_r;
  logic [SLOT_W-1:0] free_head_r, free_head_nxt;
  logic [SLOT_W-1:0] used_r, used_nxt;
  logic [SLOT_W-1:0] clr_idx_r;
  logic              out_valid_r;
  status_t           out_status_r, res_status;
  logic [SLOT_W-1:0] out_slot_r, res_slot;
  logic [SEQ_W-1:0]  out_seq_r, res_seq;

  logic              ex_we;
  row_t              ex_row;
  row_t              clr_row;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  row_t              wdata;
  logic [SLOT_W-1:0] raddr;
  logic              live;
  logic [SEQ_W-1:0]  seq_inc;

  assign sts.clr_last = (clr_idx_r == SLOT_W'(SLOTS - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  assign raddr = (op_t'(in_kind) == OP_ALLOC) ? free_head_r : in_slot;

  assign clr_row.used = 1'b0;
  assign clr_row.seq  = '0;
  assign clr_row.link = sts.clr_last ? '0 : clr_idx_r + 1'b1;

  assign live    = (op_idx_r != '0) && rd_r.used;
  assign seq_inc = rd_r.seq + 1'b1;

  always_comb begin
    ex_we         = 1'b0;
    ex_row        = rd_r;
    free_head_nxt = free_head_r;
    used_nxt      = used_r;
    res_status    = ST_OK;
    res_slot      = op_idx_r;
    res_seq       = rd_r.seq;
    if (op_kind_r == OP_ALLOC) begin
      if (op_idx_r == '0) begin
        res_status = ST_FULL;
        res_seq    = '0;
      end else begin
        ex_we         = 1'b1;
        ex_row.used   = 1'b1;
        ex_row.link   = '0;
        free_head_nxt = rd_r.link;
        used_nxt      = used_r + 1'b1;
      end
    end else if (!live) begin
      res_status = ST_BAD;
    end else begin
      unique case (op_kind_r)
        OP_FREE: begin
          ex_we         = 1'b1;
          ex_row.used   = 1'b0;
          ex_row.seq    = seq_inc;
          ex_row.link   = free_head_r;
          free_head_nxt = op_idx_r;
          used_nxt      = used_r - 1'b1;
          res_seq       = seq_inc;
        end
        OP_RETAG: begin
          ex_we      = 1'b1;
          ex_row.seq = seq_inc;
          res_seq    = seq_inc;
        end
        OP_VERIFY: begin
          if (rd_r.seq != op_tag_r) begin
            res_status = ST_STALE;
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  assign we    = cmd.clear_step || (cmd.exec && ex_we);
  assign waddr = cmd.clear_step ? clr_idx_r : op_idx_r;
  assign wdata = cmd.clear_step ? clr_row : ex_row;

  // single-port style table: at most one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.accept) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_kind_r <= op_t'(in_kind);
      op_idx_r  <= raddr;
      op_tag_r  <= in_tag;
    end
    if (cmd.exec) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_seq_r    <= res_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= SLOT_W'(1);
      used_r      <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cmd.exec) begin
        free_head_r <= free_head_nxt;
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_seq    = out_seq_r;
  assign out_used   = used_r;

endmodule
`default_nettype wire

[rtl/gsa_checker.sv]
// Port-level checks for the slot allocator, bound to the top level.
// Depends on gsa_pkg and generational_slot_allocator.
`default_nettype none
module gsa_checker
  import gsa_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [1:0]             out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while one is in flight");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |->
      (out_tdata[SLOT_W-1:0] == '0) && (out_tdata[SLOT_W+SEQ_W-1:SLOT_W] == '0))
    else $error("full result carries a slot or sequence");

  a_ok_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == ST_OK) || (out_tuser == ST_STALE)) |->
      (out_tdata[SLOT_W-1:0] != '0))
    else $error("reserved slot reported live");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
